// ----- sv/orp_adaptive_duty_controller_macros.svh -----
// Assertion macros shared by the checkers of the adaptive duty controller.
`ifndef ORP_ADAPTIVE_DUTY_CONTROLLER_MACROS_SVH
`define ORP_ADAPTIVE_DUTY_CONTROLLER_MACROS_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define OADC_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define OADC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/oadc_pkg.sv -----
// Types, constants and codes shared by the adaptive duty controller modules.
package oadc_pkg;

   // history ring
   localparam int HistoryDepth = 10;
   localparam int SlotWidth    = 4;

   // configuration port
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 32;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_ADJUST_INTERVAL = 3'd0,
      CSR_EVAL_DELAY      = 3'd1,
      CSR_LEARNING_RATE   = 3'd2,
      CSR_START_DUTY      = 3'd3,
      CSR_START_GAIN      = 3'd4
   } csr_reg_type;

   // register reset values
   localparam int ResetInterval  = 1800000;
   localparam int ResetEvalDelay = 1800000;
   localparam int ResetRate      = 1000;
   localparam int ResetDuty      = 5000;
   localparam int ResetGain      = 1000;

   // adjust arithmetic
   localparam int ErrDeadband = 250;
   localparam int StepBias    = 50000;
   localparam int StepMax     = 1000;
   localparam int StepMin     = 100;
   localparam int DutyMax     = 10000;
   localparam int ExpBias     = 10;
   localparam int ExpPosMax   = 32767;
   localparam int ExpNegMax   = 32768;

   // evaluate arithmetic
   localparam int RatioScale2 = 2000;
   localparam int RatioNoExp  = 1000;
   localparam int RatioWrong  = 100;
   localparam int RatioMin    = 100;
   localparam int RatioMax    = 3000;
   localparam int RatioLow    = 800;
   localparam int RatioHigh   = 1200;
   localparam int GainBias    = 1000;
   localparam int GainMin     = 500;
   localparam int GainMax     = 3000;

   // fixed divisions by reciprocal multiplication
   // step:  (p + 25000) / 50000 = ((p + 25000) >> 4) / 3125
   localparam int StepRound = 25000;
   localparam int StepRecip = 21990233;   // ceil(2^36 / 3125)
   localparam int StepShift = 36;
   // expected change: (7 m + 5) / 10 = ((7 m + 5) >> 1) / 5
   localparam int ExpRound  = 5;
   localparam int ExpRecip  = 419431;     // ceil(2^21 / 5)
   localparam int ExpShift  = 21;
   // gain change: (p + 500) / 1000 = ((p + 500) >> 3) / 125
   localparam int GainRound = 500;
   localparam int GainRecip = 4294968;    // ceil(2^29 / 125)
   localparam int GainShift = 29;

   // ratio divider
   localparam int DivWidth      = 30;
   localparam int DivisorWidth  = 17;
   localparam int DivSteps      = DivWidth;
   localparam int DivCountWidth = $clog2(DivSteps);

   // shared multiplier
   localparam int MulAWidth   = 17;
   localparam int MulBWidth   = 14;
   localparam int ProdWidth   = MulAWidth + MulBWidth;

   typedef struct packed {
      logic               func;
      logic [47:0]        now_ms;
      logic signed [15:0] orp_mv;
      logic signed [15:0] target_mv;
   } req_item_type;

   typedef struct packed {
      logic [13:0] duty;
      logic [11:0] gain;
      logic [11:0] ratio;
      logic        adjusted;
      logic        evaluated;
      logic [3:0]  history_slot;
   } rsp_item_type;

   typedef enum logic {
      MUL_STEP,
      MUL_GAIN
   } mul_sel_type;

   typedef enum logic [1:0] {
      DIV_STEP,
      DIV_EXP,
      DIV_RATIO,
      DIV_GAIN
   } div_sel_type;

   typedef struct packed {
      logic        load_item;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        div_start;
      div_sel_type div_sel;
      logic        apply_step;
      logic        store_exp;
      logic        store_ratio;
      logic        store_gain;
      logic        load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_eval;
      logic adj_ok;
      logic eval_ok;
      logic step_ok;
      logic need_div;
      logic div_busy;
   } ctrl_status_type;

endpackage

// ----- sv/oadc_divider.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
module oadc_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [oadc_pkg::DivWidth-1:0]      dividend,
   input  logic [oadc_pkg::DivisorWidth-1:0]  divisor,
   output logic                               busy,
   output logic [oadc_pkg::DivWidth-1:0]      quotient
);

   logic                                 busy_ff, busy_in;
   logic [oadc_pkg::DivCountWidth-1:0]   count_ff, count_in;
   logic [oadc_pkg::DivisorWidth-1:0]    rem_ff, rem_in;
   logic [oadc_pkg::DivWidth-1:0]        quo_ff, quo_in;
   logic [oadc_pkg::DivisorWidth-1:0]    dsr_ff, dsr_in;
   logic [oadc_pkg::DivisorWidth:0]      trial;
   logic                                 fits;

   assign trial = {rem_ff, quo_ff[oadc_pkg::DivWidth-1]};
   assign fits  = trial >= {1'b0, dsr_ff};

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dsr_in   = dsr_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = dividend;
         dsr_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? oadc_pkg::DivisorWidth'(trial - {1'b0, dsr_ff})
                         : trial[oadc_pkg::DivisorWidth-1:0];
         quo_in   = {quo_ff[oadc_pkg::DivWidth-2:0], fits};
         count_in = count_ff + 1'b1;
         if (count_ff == oadc_pkg::DivCountWidth'(oadc_pkg::DivSteps - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// ----- sv/oadc_datapath.sv -----
// Datapath: configuration, controller state, shared multiplier, ratio divider, result register.
module oadc_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [oadc_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [oadc_pkg::CsrDataWidth-1:0]    csr_data,
   input  oadc_pkg::req_item_type               req_item,
   input  oadc_pkg::ctrl_cmd_type               cmd,
   output oadc_pkg::ctrl_status_type            status,
   output oadc_pkg::rsp_item_type               rsp_item
);

   // configuration
   logic [31:0] interval_ff;
   logic [31:0] delay_ff;
   logic [13:0] rate_ff;

   // controller state
   logic [13:0] duty_ff;
   logic [11:0] gain_ff;
   logic [47:0] last_adjust_ff;
   logic        has_adjusted_ff;
   logic        pending_ff;
   logic [47:0] due_ff;
   logic [15:0] orp_before_ff;
   logic [15:0] expected_ff;
   logic [oadc_pkg::SlotWidth-1:0] slot_ff;

   // per item
   oadc_pkg::req_item_type item_ff;
   logic [11:0] ratio_ff;
   logic        adjusted_ff;
   logic        evaluated_ff;
   logic [oadc_pkg::ProdWidth-1:0] prod_ff;
   logic [15:0] qc_ff, qc_in;
   oadc_pkg::rsp_item_type rsp_ff;

   logic [16:0] err;
   logic        err_pos;
   logic [16:0] mag;
   logic [47:0] elapsed;
   logic        interval_ok;
   logic [16:0] actual;
   logic [16:0] act_mag;
   logic [16:0] exp_mag;
   logic        need_div;

   logic [oadc_pkg::MulAWidth-1:0] mul_a;
   logic [oadc_pkg::MulBWidth-1:0] mul_b;

   logic [27:0] step_num;
   logic [48:0] step_prod;
   logic [18:0] exp_num;
   logic [36:0] exp_prod;
   logic [24:0] gain_num;
   logic [44:0] gain_prod;

   logic                               ratio_start;
   logic                               div_busy;
   logic [oadc_pkg::DivWidth-1:0]      quo;
   logic [oadc_pkg::DivWidth-1:0]      div_dividend;
   logic [oadc_pkg::DivisorWidth-1:0]  div_divisor;

   logic [9:0]  step_mag;
   logic [14:0] duty_add;
   logic [13:0] duty_sub;
   logic [13:0] duty_next;
   logic [48:0] due_sum;
   logic [47:0] due_next;
   logic [16:0] exp_q;
   logic [15:0] exp_next;
   logic [11:0] ratio_next;
   logic [11:0] gain_dev;
   logic signed [17:0] gain_sum;
   logic [11:0] gain_next;

   // error and elapsed time
   assign err = {item_ff.orp_mv[15], item_ff.orp_mv}
              - {item_ff.target_mv[15], item_ff.target_mv};
   assign err_pos     = !err[16];
   assign mag         = err[16] ? 17'(17'd0 - err) : err;
   assign elapsed     = item_ff.now_ms - last_adjust_ff;
   assign interval_ok = !has_adjusted_ff || (elapsed >= {16'd0, interval_ff});

   // evaluation terms
   assign actual  = {item_ff.orp_mv[15], item_ff.orp_mv} - {orp_before_ff[15], orp_before_ff};
   assign act_mag = actual[16] ? 17'(17'd0 - actual) : actual;
   assign exp_mag = expected_ff[15] ? 17'(17'd0 - {1'b1, expected_ff}) : {1'b0, expected_ff};
   assign need_div = (expected_ff != 16'd0) && (actual != 17'd0)
                  && (actual[16] == expected_ff[15]);

   assign status.is_eval  = item_ff.func;
   assign status.adj_ok   = interval_ok && (mag >= 17'(oadc_pkg::ErrDeadband));
   assign status.eval_ok  = pending_ff && (item_ff.now_ms >= due_ff);
   assign status.step_ok  = step_mag >= 10'(oadc_pkg::StepMin);
   assign status.need_div = need_div;
   assign status.div_busy = div_busy;

   // shared multiplier operands
   assign gain_dev = (ratio_ff < 12'(oadc_pkg::RatioLow))  ? 12'(oadc_pkg::RatioLow) - ratio_ff :
                     (ratio_ff > 12'(oadc_pkg::RatioHigh)) ? ratio_ff - 12'(oadc_pkg::RatioHigh) :
                     12'd0;

   always_comb begin
      unique case (cmd.mul_sel)
         oadc_pkg::MUL_STEP: begin
            mul_a = mag;
            mul_b = {2'b00, gain_ff};
         end
         oadc_pkg::MUL_GAIN: begin
            mul_a = {5'd0, gain_dev};
            mul_b = rate_ff;
         end
         default: begin
            mul_a = mag;
            mul_b = {2'b00, gain_ff};
         end
      endcase
   end

   // fixed divisions: rounding bias, shift out the power of two, reciprocal multiply
   assign step_num  = prod_ff[27:0] + 28'(oadc_pkg::StepRound);
   assign step_prod = {25'd0, step_num[27:4]} * 49'(oadc_pkg::StepRecip);
   assign exp_num   = ({2'd0, mag} << 3) - {2'd0, mag} + 19'(oadc_pkg::ExpRound);
   assign exp_prod  = {19'd0, exp_num[18:1]} * 37'(oadc_pkg::ExpRecip);
   assign gain_num  = prod_ff[24:0] + 25'(oadc_pkg::GainRound);
   assign gain_prod = {23'd0, gain_num[24:3]} * 45'(oadc_pkg::GainRecip);

   always_comb begin
      qc_in = qc_ff;
      if (cmd.div_start) begin
         unique case (cmd.div_sel)
            oadc_pkg::DIV_STEP:  qc_in = {3'd0, step_prod[48:oadc_pkg::StepShift]};
            oadc_pkg::DIV_EXP:   qc_in = exp_prod[36:oadc_pkg::ExpShift];
            oadc_pkg::DIV_GAIN:  qc_in = gain_prod[44:oadc_pkg::GainShift];
            oadc_pkg::DIV_RATIO: qc_in = qc_ff;
         endcase
      end
   end

   // ratio divider: rounding bias folded into the dividend
   assign ratio_start  = cmd.div_start && (cmd.div_sel == oadc_pkg::DIV_RATIO);
   assign div_dividend = oadc_pkg::DivWidth'({13'd0, act_mag}
                       * oadc_pkg::DivWidth'(oadc_pkg::RatioScale2))
                       + {13'd0, exp_mag};
   assign div_divisor  = {exp_mag[15:0], 1'b0};

   oadc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (ratio_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (quo)
   );

   // duty step from the step quotient
   assign step_mag = (qc_ff > 16'(oadc_pkg::StepMax))
                   ? 10'(oadc_pkg::StepMax) : qc_ff[9:0];
   assign duty_add = {1'b0, duty_ff} + {5'd0, step_mag};
   assign duty_sub = duty_ff - {4'd0, step_mag};

   always_comb begin
      if (err_pos) begin
         duty_next = (duty_ff < {4'd0, step_mag})      ? 14'd0 :
                     (duty_sub > 14'(oadc_pkg::DutyMax)) ? 14'(oadc_pkg::DutyMax) :
                     duty_sub;
      end else begin
         duty_next = (duty_add > 15'(oadc_pkg::DutyMax)) ? 14'(oadc_pkg::DutyMax)
                                                          : duty_add[13:0];
      end
   end

   assign due_sum  = {1'b0, item_ff.now_ms} + {17'd0, delay_ff};
   assign due_next = due_sum[48] ? '1 : due_sum[47:0];

   // expected change, saturated to 16 bits signed
   assign exp_q = {1'b0, qc_ff};

   always_comb begin
      if (err_pos) begin
         exp_next = (exp_q > 17'(oadc_pkg::ExpNegMax)) ? 16'h8000
                                                        : 16'(17'd0 - exp_q);
      end else begin
         exp_next = (exp_q > 17'(oadc_pkg::ExpPosMax)) ? 16'h7FFF : exp_q[15:0];
      end
   end

   // ratio source
   always_comb begin
      if (need_div) begin
         ratio_next = (quo < oadc_pkg::DivWidth'(oadc_pkg::RatioMin)) ? 12'(oadc_pkg::RatioMin) :
                      (quo > oadc_pkg::DivWidth'(oadc_pkg::RatioMax)) ? 12'(oadc_pkg::RatioMax) :
                      quo[11:0];
      end else if (expected_ff == 16'd0) begin
         ratio_next = 12'(oadc_pkg::RatioNoExp);
      end else begin
         ratio_next = 12'(oadc_pkg::RatioWrong);
      end
   end

   // gain update from the gain quotient
   always_comb begin
      if (ratio_ff < 12'(oadc_pkg::RatioLow)) begin
         gain_sum = $signed({6'd0, gain_ff}) + $signed({2'b00, qc_ff});
      end else if (ratio_ff > 12'(oadc_pkg::RatioHigh)) begin
         gain_sum = $signed({6'd0, gain_ff}) - $signed({2'b00, qc_ff});
      end else begin
         gain_sum = $signed({6'd0, gain_ff});
      end
      if (gain_sum < $signed(18'(oadc_pkg::GainMin))) begin
         gain_next = 12'(oadc_pkg::GainMin);
      end else if (gain_sum > $signed(18'(oadc_pkg::GainMax))) begin
         gain_next = 12'(oadc_pkg::GainMax);
      end else begin
         gain_next = gain_sum[11:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff     <= 32'(oadc_pkg::ResetInterval);
         delay_ff        <= 32'(oadc_pkg::ResetEvalDelay);
         rate_ff         <= 14'(oadc_pkg::ResetRate);
         duty_ff         <= 14'(oadc_pkg::ResetDuty);
         gain_ff         <= 12'(oadc_pkg::ResetGain);
         last_adjust_ff  <= '0;
         has_adjusted_ff <= 1'b0;
         pending_ff      <= 1'b0;
         due_ff          <= '0;
         orp_before_ff   <= '0;
         expected_ff     <= '0;
         slot_ff         <= '0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               oadc_pkg::CSR_ADJUST_INTERVAL: interval_ff <= csr_data;
               oadc_pkg::CSR_EVAL_DELAY:      delay_ff    <= csr_data;
               oadc_pkg::CSR_LEARNING_RATE:   rate_ff     <= csr_data[13:0];
               oadc_pkg::CSR_START_DUTY:      duty_ff     <= csr_data[13:0];
               oadc_pkg::CSR_START_GAIN:      gain_ff     <= csr_data[11:0];
               default: ;
            endcase
         end
         if (cmd.apply_step) begin
            duty_ff         <= duty_next;
            orp_before_ff   <= item_ff.orp_mv;
            pending_ff      <= 1'b1;
            due_ff          <= due_next;
            last_adjust_ff  <= item_ff.now_ms;
            has_adjusted_ff <= 1'b1;
         end
         if (cmd.store_exp) begin
            expected_ff <= exp_next;
         end
         if (cmd.store_ratio) begin
            pending_ff <= 1'b0;
         end
         if (cmd.store_gain) begin
            gain_ff <= gain_next;
            slot_ff <= (slot_ff == oadc_pkg::SlotWidth'(oadc_pkg::HistoryDepth - 1))
                     ? '0 : slot_ff + 1'b1;
         end
      end
   end

   // item, operand and result registers
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff      <= req_item;
         ratio_ff     <= '0;
         adjusted_ff  <= 1'b0;
         evaluated_ff <= 1'b0;
      end
      if (cmd.mul_en) begin
         prod_ff <= {14'd0, mul_a} * {17'd0, mul_b};
      end
      qc_ff <= qc_in;
      if (cmd.apply_step) begin
         adjusted_ff <= 1'b1;
      end
      if (cmd.store_ratio) begin
         ratio_ff <= ratio_next;
      end
      if (cmd.store_gain) begin
         evaluated_ff <= 1'b1;
      end
      if (cmd.load_rsp) begin
         rsp_ff.duty         <= duty_ff;
         rsp_ff.gain         <= gain_ff;
         rsp_ff.ratio        <= ratio_ff;
         rsp_ff.adjusted     <= adjusted_ff;
         rsp_ff.evaluated    <= evaluated_ff;
         rsp_ff.history_slot <= slot_ff;
      end
   end

   assign rsp_item = rsp_ff;

endmodule

// ----- sv/oadc_ctrl.sv -----
// Controller: sequences one item through the datapath and owns the handshakes.
module oadc_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  oadc_pkg::ctrl_status_type   status,
   output oadc_pkg::ctrl_cmd_type      cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_ADJ_MUL,
      ST_ADJ_DIV,
      ST_ADJ_WAIT,
      ST_APPLY,
      ST_EXP_WAIT,
      ST_EVAL_START,
      ST_RATIO_WAIT,
      ST_EVAL_MUL,
      ST_GAIN_DIV,
      ST_GAIN_WAIT,
      ST_RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.mul_sel   = oadc_pkg::MUL_STEP;
      cmd.div_sel   = oadc_pkg::DIV_STEP;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (!status.is_eval) begin
               state_in = status.adj_ok ? ST_ADJ_MUL : ST_RESULT;
            end else begin
               state_in = status.eval_ok ? ST_EVAL_START : ST_RESULT;
            end
         end
         ST_ADJ_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = oadc_pkg::MUL_STEP;
            state_in    = ST_ADJ_DIV;
         end
         ST_ADJ_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = oadc_pkg::DIV_STEP;
            state_in      = ST_ADJ_WAIT;
         end
         ST_ADJ_WAIT: begin
            if (!status.div_busy) begin
               state_in = status.step_ok ? ST_APPLY : ST_RESULT;
            end
         end
         ST_APPLY: begin
            cmd.apply_step = 1'b1;
            cmd.div_start  = 1'b1;
            cmd.div_sel    = oadc_pkg::DIV_EXP;
            state_in       = ST_EXP_WAIT;
         end
         ST_EXP_WAIT: begin
            if (!status.div_busy) begin
               cmd.store_exp = 1'b1;
               state_in      = ST_RESULT;
            end
         end
         ST_EVAL_START: begin
            if (status.need_div) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = oadc_pkg::DIV_RATIO;
               state_in      = ST_RATIO_WAIT;
            end else begin
               cmd.store_ratio = 1'b1;
               state_in        = ST_EVAL_MUL;
            end
         end
         ST_RATIO_WAIT: begin
            cmd.div_sel = oadc_pkg::DIV_RATIO;
            if (!status.div_busy) begin
               cmd.store_ratio = 1'b1;
               state_in        = ST_EVAL_MUL;
            end
         end
         ST_EVAL_MUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = oadc_pkg::MUL_GAIN;
            state_in    = ST_GAIN_DIV;
         end
         ST_GAIN_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = oadc_pkg::DIV_GAIN;
            state_in      = ST_GAIN_WAIT;
         end
         ST_GAIN_WAIT: begin
            if (!status.div_busy) begin
               cmd.store_gain = 1'b1;
               state_in       = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- sv/orp_adaptive_duty_controller.sv -----
// Top level of the self-tuning ORP duty controller.
//
// Each item is either an adjust request (func 0) or an evaluation check
// (func 1) and yields exactly one result item carrying the duty, the gain,
// the effectiveness ratio, the adjusted/evaluated flags and the history slot.
// Items are handled one at a time: req_ready is high only while the
// controller is idle, and the result sits in an output register so the next
// item can be taken while that result still waits for rsp_ready. An item
// can be turned away by the interval, the deadband or the due time, and an
// adjust whose step rounds below 1 % leaves the duty unchanged. When the
// actual and expected change are nonzero and agree in sign the ratio goes
// through a 30-step restoring divider; that divider sets the pace. The next
// item can be accepted in the cycle after its result is loaded. The fixed
// divisions of the step, the expected change and the gain change are
// reciprocal multiplies. Configuration writes are always accepted
// (csr_ready tied high) and take effect at once; they are meant to be issued
// only while the block is idle. Writing start_duty or start_gain also
// reloads the live duty or gain.
module orp_adaptive_duty_controller (
   input  logic                                 clock,
   input  logic                                 reset,

   // item in
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  oadc_pkg::req_item_type               req_item,

   // result out
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output oadc_pkg::rsp_item_type               rsp_item,

   // configuration writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [oadc_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [oadc_pkg::CsrDataWidth-1:0]    csr_data
);

   oadc_pkg::ctrl_cmd_type    cmd;
   oadc_pkg::ctrl_status_type status;

   // register writes never stall
   assign csr_ready = 1'b1;

   oadc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath holds all tuning state, the multiplier and the divider
   oadc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_item  (req_item),
      .cmd       (cmd),
      .status    (status),
      .rsp_item  (rsp_item)
   );

endmodule

// ----- sv/oadc_checker.sv -----
// Port-level checker for the adaptive duty controller, bound to the top level.
`include "orp_adaptive_duty_controller_macros.svh"

module oadc_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input oadc_pkg::rsp_item_type  rsp_item
);

   `OADC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_item), "stalled result item changed")
   `OADC_ASSERT_IMPLY(a_one_action, rsp_valid, !(rsp_item.adjusted && rsp_item.evaluated), "item both adjusted and evaluated")
   `OADC_ASSERT_IMPLY(a_ratio_zero, rsp_valid && !rsp_item.evaluated, rsp_item.ratio == 12'd0, "ratio set without evaluation")
   `OADC_ASSERT_IMPLY(a_eval_range, rsp_valid && rsp_item.evaluated, rsp_item.ratio >= 12'd100 && rsp_item.ratio <= 12'd3000 && rsp_item.gain >= 12'd500 && rsp_item.gain <= 12'd3000, "evaluated ratio or gain out of range")
   `OADC_ASSERT_IMPLY(a_slot_range, rsp_valid, rsp_item.history_slot < 4'd10, "history slot out of range")

endmodule

bind orp_adaptive_duty_controller oadc_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);
